@@ rtl/swm_pkg.sv @@
// Package for the sliding window maximum block.
// Holds sizes, the cell record type and its array type; no dependencies.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_W        = 7;

    // Cell index width and a window-length width that holds 1..WINDOW_MAX
    localparam int WIN_IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIN_CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int K_W       = (WIN_CNT_W > CFG_W) ? WIN_CNT_W : CFG_W;

    // One stage of the sample chain: age is the cell's position
    typedef struct packed {
        logic                    valid;  // sample belongs to current sequence
        logic                    cand;   // no newer sample is larger
        logic [SAMPLE_WIDTH-1:0] value;
    } cell_t;

    typedef cell_t [WINDOW_MAX-1:0] cell_row_t;

endpackage

`default_nettype wire

@@ rtl/swm_cell.sv @@
// One cell of the sample chain: takes its newer neighbor's contents on each item.
// Depends on swm_pkg.
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    shift,
    input  wire logic                    clr,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    input  wire cell_t                   prev,
    output cell_t                        cur
);

    logic                    valid_reg;
    logic                    valid_next;
    logic                    cand_reg;
    logic                    cand_next;
    logic [SAMPLE_WIDTH-1:0] value_reg;
    logic [SAMPLE_WIDTH-1:0] value_next;
    logic                    beaten;

    // strictly smaller: an older equal sample stays a candidate
    assign beaten = $signed(prev.value) < $signed(sample);

    always_comb
    begin
        valid_next = prev.valid & ~clr;
        cand_next  = prev.cand & prev.valid & ~clr & ~beaten;
        value_next = prev.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= value_next;
        end
    end

    always_comb
    begin
        cur.valid = valid_reg;
        cur.cand  = cand_reg;
        cur.value = value_reg;
    end

endmodule

`default_nettype wire

@@ rtl/swm_select.sv @@
// Picks the oldest candidate inside the window from the cell row.
// Depends on swm_pkg.
`default_nettype none

module swm_select
    import swm_pkg::*;
(
    input  wire cell_row_t               cells,
    input  wire logic [K_W-1:0]          win_len,
    output logic                         win_full,
    output logic [SAMPLE_WIDTH-1:0]      max_value
);

    logic [WINDOW_MAX-1:0] mask;
    logic [WINDOW_MAX-1:0] mask_rev;
    logic [WINDOW_MAX-1:0] pick_rev;
    logic [WINDOW_MAX-1:0] pick;
    logic [K_W-1:0]        last_pos;

    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            mask[i] = cells[i].valid & cells[i].cand & (K_W'(i) < win_len);
            mask_rev[WINDOW_MAX-1-i] = mask[i];
        end
    end

    // lowest set bit of the reversed mask = oldest candidate in window
    assign pick_rev = mask_rev & (~mask_rev + WINDOW_MAX'(1));

    always_comb
    begin
        max_value = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            pick[i]   = pick_rev[WINDOW_MAX-1-i];
            max_value = max_value | (cells[i].value & {SAMPLE_WIDTH{pick[i]}});
        end
    end

    // window full once the sample at the window's far edge is present
    assign last_pos = win_len - K_W'(1);
    assign win_full = cells[last_pos[WIN_IDX_W-1:0]].valid;

endmodule

`default_nettype wire

@@ rtl/sliding_window_maximum.sv @@
// Sliding window maximum: one signed sample in, maximum of the last window_size out.
// An accepted sample shifts the chain; its result is registered in window_max when it advances.
// Throughput: one item per cycle while the output side takes results; the
//   64-cell sample chain shifts once per item and one selection stage follows.
// Reset: window_size returns to 1, all cells empty, no result pending.
// Depends on swm_pkg, swm_cell, swm_select.
`default_nettype none

module sliding_window_maximum
    import swm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // config write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_W-1:0]        window_size,
    // sample channel
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                    first,
    // result channel
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0]      window_max
);

    logic [CFG_W-1:0]        win_size_reg;
    logic [K_W-1:0]          win_len;
    logic                    in_acc;
    logic                    advance;
    logic                    pend_reg;
    logic                    pend_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SAMPLE_WIDTH-1:0] window_max_reg;
    logic                    win_full;
    logic [SAMPLE_WIDTH-1:0] max_value;
    cell_t                   head;
    cell_row_t               cells;

    // ---------------------------------------------------------------
    // Config: one register, always writable (unchecked; user must write it only while idle)
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg <= CFG_W'(1);
        end
        else if (cfg_valid)
        begin
            win_size_reg <= window_size;
        end
    end

    // Effective window: zero acts as 1, oversize clamps to the chain length
    always_comb
    begin
        if (win_size_reg == '0)
        begin
            win_len = K_W'(1);
        end
        else if (K_W'(win_size_reg) > K_W'(WINDOW_MAX))
        begin
            win_len = K_W'(WINDOW_MAX);
        end
        else
        begin
            win_len = K_W'(win_size_reg);
        end
    end

    // ---------------------------------------------------------------
    // Handshake. An accepted item shifts the chain and leaves one
    // pending evaluation; the next item may enter in the same cycle
    // that the evaluation moves to the output register.
    // ---------------------------------------------------------------
    assign advance  = pend_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~pend_reg | advance;
    assign in_acc   = in_valid & in_ready;

    // ---------------------------------------------------------------
    // Sample chain: cell i holds the sample of age i. The new sample
    // enters cell 0; every older cell loses its candidate mark when
    // the new sample is larger, and a first item empties the chain.
    // ---------------------------------------------------------------
    always_comb
    begin
        head.valid = 1'b1;
        head.cand  = 1'b1;
        head.value = sample;
    end

    generate
        for (genvar g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                swm_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (in_acc),
                    .clr    (1'b0),
                    .sample (sample),
                    .prev   (head),
                    .cur    (cells[g])
                );
            end
            else
            begin : g_body
                swm_cell u_cell (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (in_acc),
                    .clr    (first),
                    .sample (sample),
                    .prev   (cells[g-1]),
                    .cur    (cells[g])
                );
            end
        end
    endgenerate

    // Oldest in-window candidate is the maximum
    swm_select u_select (
        .cells     (cells),
        .win_len   (win_len),
        .win_full  (win_full),
        .max_value (max_value)
    );

    // ---------------------------------------------------------------
    // Pending flag and output register. No result while the sequence
    // is shorter than the window.
    // ---------------------------------------------------------------
    always_comb
    begin
        pend_next = pend_reg;
        if (advance)
        begin
            pend_next = 1'b0;
        end
        if (in_acc)
        begin
            pend_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = win_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && win_full)
        begin
            window_max_reg <= max_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_sliding_window_maximum.sv @@
// Testbench for sliding_window_maximum: directed and random sample streams,
// with a predictor of the windowed maximum and an in-order result check.
// Depends on swm_pkg and the sliding_window_maximum RTL.
`timescale 1ns / 100ps

module tb_sliding_window_maximum
    import swm_pkg::*;
();

    localparam int IDLE_PCT     = 8;     // idle chance in percent: per item sent, per receiver cycle
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;     // drain margin over the block's latency
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int EXP_DEPTH    = 4096;  // expected-result store

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        window_size;
    logic                    in_valid;
    logic                    in_ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    first;
    logic                    out_valid;
    logic                    out_ready;
    logic [SAMPLE_WIDTH-1:0] window_max;

    sliding_window_maximum uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .window_size (window_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .first       (first),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .window_max  (window_max)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: monotonic candidate list, oldest first.
    // Values never increase front to back; age 0 is the newest sample.
    // ------------------------------------------------------------------
    logic [SAMPLE_WIDTH-1:0] cand_value [0:WINDOW_MAX-1];
    int unsigned             cand_age   [0:WINDOW_MAX-1];
    int unsigned             cand_cnt;
    int unsigned             fill_cnt;
    logic [CFG_W-1:0]        win_setting;

    // Expected results in order: written by the sender, read by the checker
    logic [SAMPLE_WIDTH-1:0] expected_max [0:EXP_DEPTH-1];
    int                      exp_wr = 0;
    int                      exp_rd = 0;

    int  mismatches = 0;
    bit  quiet;          // no idling on either side while set
    bit  hold_pending;   // request one long receiver hold-off
    int  stall_cycles = 0;
    logic [SAMPLE_WIDTH-1:0] want_max;

    // Window as the block applies it: zero acts as 1, large values clip.
    function automatic int unsigned eff_window();
        if (win_setting == 0)
            return 1;
        if (win_setting > WINDOW_MAX)
            return WINDOW_MAX;
        return win_setting;
    endfunction

    function automatic void predict_window_max(input logic [SAMPLE_WIDTH-1:0] s,
                                               input logic f,
                                               output bit produced,
                                               output logic [SAMPLE_WIDTH-1:0] max_val);
        int unsigned k;
        k = eff_window();
        produced = 1'b0;
        max_val  = s;
        if (f)
        begin
            cand_cnt = 0;
            fill_cnt = 0;
        end
        // Age everything; the list tracks the largest possible window,
        // regardless of the current setting.
        for (int i = 0; i < cand_cnt; i++)
            cand_age[i]++;
        if (cand_cnt > 0 && cand_age[0] >= WINDOW_MAX)
        begin
            for (int i = 1; i < cand_cnt; i++)
            begin
                cand_value[i-1] = cand_value[i];
                cand_age[i-1]   = cand_age[i];
            end
            cand_cnt--;
        end
        // Smaller candidates can never win again; equal older ones stay.
        while (cand_cnt > 0 && $signed(cand_value[cand_cnt-1]) < $signed(s))
            cand_cnt--;
        if (cand_cnt >= WINDOW_MAX)
            cand_cnt = WINDOW_MAX - 1;
        cand_value[cand_cnt] = s;
        cand_age[cand_cnt]   = 0;
        cand_cnt++;
        if (fill_cnt < WINDOW_MAX)
            fill_cnt++;
        if (fill_cnt < k)
            return;
        // Oldest candidate still inside the window holds the maximum
        produced = 1'b1;
        for (int i = 0; i < cand_cnt; i++)
        begin
            if (cand_age[i] < k)
            begin
                max_val = cand_value[i];
                break;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side: one item per call, a random idle cycle ahead of it.
    // in_valid stays high across back-to-back items.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] s, input logic f);
        bit                      produced;
        logic [SAMPLE_WIDTH-1:0] max_val;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        first    <= f;
        do @(posedge clk); while (!in_ready);
        predict_window_max(s, f, produced, max_val);
        if (produced)
        begin
            expected_max[exp_wr % EXP_DEPTH] = max_val;
            exp_wr++;
        end
    endtask

    // Register writes only with the block drained. Samples that give no
    // result may still be in flight, so allow the latency on top.
    task automatic write_window(input logic [CFG_W-1:0] w);
        in_valid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid   <= 1'b1;
        window_size <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        win_setting = w;
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample(input int style,
                                                            input logic [SAMPLE_WIDTH-1:0] base,
                                                            input int pos);
        case (style)
            0: return $urandom;
            1: return SAMPLE_WIDTH'($signed($urandom_range(0, 6)) - 3);  // many equals
            2: return base - SAMPLE_WIDTH'(pos);   // falling: long candidate list
            3: return base + SAMPLE_WIDTH'(pos);   // rising: list collapses each item
            default:
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                    1: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // Mostly full sequences at least as long as the window with random content;
    // about one in seven is no longer than the window and may give no result.
    task automatic run_random_phase(input logic [CFG_W-1:0] w, input int n_items);
        int                      sent;
        int                      len;
        int                      style;
        int unsigned             k;
        logic [SAMPLE_WIDTH-1:0] base;
        bit                      lead;
        write_window(w);
        k    = eff_window();
        sent = 0;
        lead = 1'b1;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
                len = $urandom_range(1, k);
            else
                len = k + $urandom_range(0, 80);
            style = $urandom_range(0, 4);
            base  = $urandom;
            for (int j = 0; j < len && sent < n_items; j++)
            begin
                // first sequence of a phase may carry on across the new window
                send_sample(pick_sample(style, base, j),
                            (j == 0) && (!lead || $urandom_range(0, 1)));
                sent++;
            end
            lead = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Named tests
    // ------------------------------------------------------------------

    // Window of 1 out of reset: every sample echoes, incl. both extremes.
    task automatic test_default_window();
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
    endtask

    // Window size zero acts as a window of one.
    task automatic test_window_zero();
        write_window('0);
        send_sample(32'd5, 1'b1);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'd7, 1'b0);
    endtask

    // Equal samples, then a sequence too short to give a result, then negative samples.
    task automatic test_equal_and_short();
        write_window(7'd3);
        send_sample(32'd9, 1'b1);
        send_sample(32'd9, 1'b0);
        send_sample(32'd9, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd100, 1'b1);
        send_sample(32'd50, 1'b0);
        send_sample(-32'sd1, 1'b1);
        send_sample(-32'sd1, 1'b0);
        send_sample(-32'sd2, 1'b0);
    endtask

    // Window changed inside a sequence, then the largest setting, which
    // clips to the chain length; two samples give nothing there.
    task automatic test_window_change();
        write_window(7'd2);
        send_sample(32'd3, 1'b1);
        send_sample(32'd8, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd4, 1'b0);
        write_window(7'd5);
        send_sample(32'd0, 1'b0);
        send_sample(-32'sd3, 1'b0);
        send_sample(32'd2, 1'b0);
        write_window('1);
        send_sample(32'd6, 1'b1);
        send_sample(32'd7, 1'b0);
    endtask

    // Receiver holds off for a long stretch while items keep coming, so
    // the block backs up and must drop in_ready. Drain first so the
    // hold-off lands on the new items.
    task automatic test_output_backpressure();
        write_window(7'd2);
        hold_pending = 1'b1;
        run_random_phase(7'd2, 200);
    endtask

    // No idling on either side: full rate through a mid-size window.
    task automatic test_full_rate();
        quiet = 1'b1;
        run_random_phase(7'd5, 150);
        quiet = 1'b0;
    endtask

    task automatic test_random_windows();
        run_random_phase(7'd1, 120);
        run_random_phase(7'd64, 300);
        run_random_phase('1, 200);
        run_random_phase('0, 80);
        run_random_phase(7'd17, 150);
        run_random_phase(7'd40, 120);
        run_random_phase(7'd3, 100);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_rd == exp_wr)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, window_max);
            end
            else
            begin
                want_max = expected_max[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (window_max !== want_max)
                begin
                    mismatches++;
                    $display("%0t: window_max expected %h actual %h",
                             $time, want_max, window_max);
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        window_size  = '0;
        in_valid     = 1'b0;
        sample       = '0;
        first        = 1'b0;
        quiet        = 1'b0;
        hold_pending = 1'b0;
        cand_cnt     = 0;
        fill_cnt     = 0;
        win_setting  = 7'd1;   // reset value of the register
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_window_zero();
        test_equal_and_short();
        test_window_change();
        test_random_windows();
        test_output_backpressure();
        test_full_rate();

        in_valid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_select.sv
rtl/sliding_window_maximum.sv
tb/sv/tb_sliding_window_maximum.sv
